/* hw/rtl/rgbf_pkg.sv */
// Shared types, constants and gamma table for the RGB fade and gamma PWM block.
`default_nettype none

package rgbf_pkg;

  localparam int unsigned LEVEL_W  = 5;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned NUM_PH   = 6;

  localparam logic [LEVEL_W-1:0]  LEVEL_TOP   = 5'd31;
  localparam logic [COUNT_W-1:0]  PWM_RELOAD  = 8'd255;
  localparam logic [PERIOD_W-1:0] STEP_TICKS_RST = 16'd4688;

  // Fade phase codes
  localparam logic [PHASE_W-1:0] PH_RED_UP    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_GREEN_DN  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_BLUE_UP   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RED_DN    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_GREEN_UP  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_BLUE_DN   = 3'd5;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [PHASE_W-1:0] phase_t;

  typedef struct packed {
    level_t red;
    level_t green;
    level_t blue;
  } level_set_t;

  // Gamma-corrected duty threshold for a 5-bit level
  function automatic logic [COUNT_W-1:0] gamma_lut(input level_t lvl);
    logic [COUNT_W-1:0] g;
    case (lvl)
      5'd0:  g = 8'd0;    5'd1:  g = 8'd1;    5'd2:  g = 8'd2;    5'd3:  g = 8'd2;
      5'd4:  g = 8'd2;    5'd5:  g = 8'd3;    5'd6:  g = 8'd3;    5'd7:  g = 8'd4;
      5'd8:  g = 8'd5;    5'd9:  g = 8'd6;    5'd10: g = 8'd7;    5'd11: g = 8'd8;
      5'd12: g = 8'd10;   5'd13: g = 8'd11;   5'd14: g = 8'd13;   5'd15: g = 8'd16;
      5'd16: g = 8'd19;   5'd17: g = 8'd23;   5'd18: g = 8'd27;   5'd19: g = 8'd32;
      5'd20: g = 8'd38;   5'd21: g = 8'd45;   5'd22: g = 8'd54;   5'd23: g = 8'd64;
      5'd24: g = 8'd76;   5'd25: g = 8'd91;   5'd26: g = 8'd108;  5'd27: g = 8'd128;
      5'd28: g = 8'd152;  5'd29: g = 8'd181;  5'd30: g = 8'd215;  default: g = 8'd255;
    endcase
    return g;
  endfunction

  // Next phase in the six-phase rotation
  function automatic phase_t phase_inc(input phase_t p);
    return (p == PH_BLUE_DN) ? PH_RED_UP : phase_t'(p + 3'd1);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rgbf_fade_step.sv */
// Fade sequencer step: skips finished phases and moves one level by one.
`default_nettype none

module rgbf_fade_step (
  input  rgbf_pkg::level_set_t lvl_i,
  input  rgbf_pkg::phase_t     phase_i,
  output rgbf_pkg::level_set_t lvl_o,
  output rgbf_pkg::phase_t     phase_o
);
  import rgbf_pkg::*;

  logic [NUM_PH-1:0] has_work;
  phase_t            start_ph;
  phase_t            scan_ph;
  phase_t            sel_ph;
  logic              found;

  // Work left in each phase
  assign has_work[PH_RED_UP]   = (lvl_i.red   < LEVEL_TOP);
  assign has_work[PH_GREEN_DN] = (lvl_i.green != '0);
  assign has_work[PH_BLUE_UP]  = (lvl_i.blue  < LEVEL_TOP);
  assign has_work[PH_RED_DN]   = (lvl_i.red   != '0);
  assign has_work[PH_GREEN_UP] = (lvl_i.green < LEVEL_TOP);
  assign has_work[PH_BLUE_DN]  = (lvl_i.blue  != '0);

  assign start_ph = (phase_i > PH_BLUE_DN) ? PH_RED_UP : phase_i;

  // Find the first phase with work, starting at the current one
  always_comb begin
    found   = 1'b0;
    sel_ph  = start_ph;
    scan_ph = start_ph;
    for (int i = 0; i < NUM_PH; i++) begin
      if (!found && has_work[scan_ph]) begin
        found  = 1'b1;
        sel_ph = scan_ph;
      end
      scan_ph = phase_inc(scan_ph);
    end
  end

  // Apply one step to the chosen phase's level
  always_comb begin
    lvl_o = lvl_i;
    if (found) begin
      unique case (sel_ph)
        PH_RED_UP:   lvl_o.red   = lvl_i.red   + 5'd1;
        PH_GREEN_DN: lvl_o.green = lvl_i.green - 5'd1;
        PH_BLUE_UP:  lvl_o.blue  = lvl_i.blue  + 5'd1;
        PH_RED_DN:   lvl_o.red   = lvl_i.red   - 5'd1;
        PH_GREEN_UP: lvl_o.green = lvl_i.green + 5'd1;
        PH_BLUE_DN:  lvl_o.blue  = lvl_i.blue  - 5'd1;
        default:     lvl_o = lvl_i;
      endcase
    end
  end

  assign phase_o = sel_ph;

endmodule

`default_nettype wire

/* hw/rtl/rgb_fade_gamma_pwm_top.sv */
// Top level of the RGB color-fade LED driver with gamma-corrected PWM.
`default_nettype none

// Each input transfer is one PWM tick (tdata bit 0 set) or an idle report
// (bit 0 clear); every input transfer yields exactly one result transfer
// with the drive bits, the three levels and the fade phase as they stand
// after that tick. All state updates in the cycle of the input transfer,
// through one level of logic into the result register, so the block takes
// one item per clock cycle; input ready drops only while the result
// register is full and the sink holds it. The user must write step_ticks through
// cfg_* only while the block is idle; the block does not enforce this. 0 acts as 1.
module rgb_fade_gamma_pwm_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // cfg: step_ticks
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  // in_tdata: [0] tick_valid, [7:1] zero
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  // out_tdata: [0] red_drive, [1] green_drive, [2] blue_drive, [7:3] red_level,
  //            [12:8] green_level, [17:13] blue_level, [20:18] fade_phase_out,
  //            [23:21] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata
);
  import rgbf_pkg::*;

  logic [PERIOD_W-1:0] step_ticks_r;
  logic [PERIOD_W-1:0] step_delay_r, step_delay_nxt;
  logic [COUNT_W-1:0]  pwm_count_r, pwm_count_nxt, pwm_eff;
  logic [2:0]          drive_r, drive_nxt, drive_base;
  level_set_t          lvl_r, lvl_nxt, lvl_step;
  phase_t              phase_r, phase_nxt, phase_step;
  logic                out_valid_r;
  logic [23:0]         out_data_r;
  logic                in_xfer;
  logic                tick;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign tick       = in_tdata[0];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Hold the fade period
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ticks_r <= STEP_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      step_ticks_r <= cfg_data;
    end
  end

  rgbf_fade_step u_fade (
    .lvl_i   (lvl_r),
    .phase_i (phase_r),
    .lvl_o   (lvl_step),
    .phase_o (phase_step)
  );

  // PWM counter and sticky drive bits, compared against the levels held now
  always_comb begin
    pwm_eff    = (pwm_count_r == '0) ? PWM_RELOAD : pwm_count_r;
    drive_base = (pwm_count_r == '0) ? 3'b000 : drive_r;
    drive_nxt  = drive_base;
    if (pwm_eff <= gamma_lut(lvl_r.red))   drive_nxt[2] = 1'b1;
    if (pwm_eff <= gamma_lut(lvl_r.green)) drive_nxt[1] = 1'b1;
    if (pwm_eff <= gamma_lut(lvl_r.blue))  drive_nxt[0] = 1'b1;
    pwm_count_nxt = pwm_eff - 8'd1;
  end

  // Fade timing: step when the delay runs out, then reload
  always_comb begin
    lvl_nxt   = lvl_r;
    phase_nxt = phase_r;
    if (step_delay_r == '0) begin
      lvl_nxt        = lvl_step;
      phase_nxt      = phase_step;
      step_delay_nxt = (step_ticks_r == '0) ? '0 : step_ticks_r - 16'd1;
    end else begin
      step_delay_nxt = step_delay_r - 16'd1;
    end
  end

  // Advance state on a tick transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_count_r  <= '0;
      drive_r      <= '0;
      lvl_r        <= '0;
      phase_r      <= PH_RED_UP;
      step_delay_r <= '0;
    end else if (in_xfer && tick) begin
      pwm_count_r  <= pwm_count_nxt;
      drive_r      <= drive_nxt;
      lvl_r        <= lvl_nxt;
      phase_r      <= phase_nxt;
      step_delay_r <= step_delay_nxt;
    end
  end

  // Result register: load on input transfer, drop after output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (tick) begin
        out_data_r <= {3'b000, phase_nxt, lvl_nxt.blue, lvl_nxt.green, lvl_nxt.red,
                       drive_nxt[0], drive_nxt[1], drive_nxt[2]};
      end else begin
        out_data_r <= {3'b000, phase_r, lvl_r.blue, lvl_r.green, lvl_r.red,
                       drive_r[0], drive_r[1], drive_r[2]};
      end
    end
  end

  // An input transfer always leaves a result waiting
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("result missing after input transfer");

  // Levels and phase move only on a tick transfer
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_xfer && tick) |=> ($stable(lvl_r) && $stable(phase_r)))
    else $error("fade state changed without a tick");

  // At most one level changes per tick
  a_one_level: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && tick) |=> $countones({lvl_r.red != $past(lvl_r.red),
                                      lvl_r.green != $past(lvl_r.green),
                                      lvl_r.blue != $past(lvl_r.blue)}) <= 1)
    else $error("more than one level stepped in a tick");

  // Phase stays within the rotation
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_BLUE_DN)
    else $error("fade phase out of range");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for the RGB fade and gamma PWM block: random ticks checked against a local predictor.
`timescale 1ns / 1ps

module tb;
  import rgbf_pkg::*;

  // Clock, reset and block ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;       // [0] tick_valid, [7:1] zero
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [23:0] out_tdata;           // [0] red, [1] green, [2] blue drive, [7:3] red level,
                                    // [12:8] green level, [17:13] blue level, [20:18] phase

  rgb_fade_gamma_pwm_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Gamma thresholds, level 0 in the lowest byte
  localparam logic [255:0] GAMMA_BYTES = {
    8'd255, 8'd215, 8'd181, 8'd152, 8'd128, 8'd108, 8'd91, 8'd76,
    8'd64,  8'd54,  8'd45,  8'd38,  8'd32,  8'd27,  8'd23, 8'd19,
    8'd16,  8'd13,  8'd11,  8'd10,  8'd8,   8'd7,   8'd6,  8'd5,
    8'd4,   8'd3,   8'd3,   8'd2,   8'd2,   8'd2,   8'd1,  8'd0
  };

  typedef struct packed {
    logic   red_on;
    logic   green_on;
    logic   blue_on;
    level_t red;
    level_t green;
    level_t blue;
    phase_t phase;
  } led_state_t;

  typedef enum logic [1:0] {JOB_TICK, JOB_CFG, JOB_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t   kind;
    logic [15:0] val;
    bit          gapless;
  } pending_job_t;

  pending_job_t job_q[$];
  led_state_t   led_expect_q[$];

  // Predicted block state
  logic [7:0]  pwm_cnt;
  logic [2:0]  drive;              // [2] red, [1] green, [0] blue
  level_t      lvl [3];            // 0 red, 1 green, 2 blue
  phase_t      fade_ph;
  logic [15:0] step_dly;
  logic [15:0] step_period;

  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sink_hold = 0;
  bit          long_hold_done = 1'b0;
  bit          in_fired = 1'b0;
  bit          cfg_fired = 1'b0;

  // Generate the clock
  initial begin
    forever #5 clk = ~clk;
  end

  // End the run if it hangs
  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

  task automatic report(string what, int want, int got);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    errors++;
  endtask

  function automatic int channel_of(phase_t p);
    case (p) inside
      PH_RED_UP, PH_RED_DN:     return 0;
      PH_GREEN_DN, PH_GREEN_UP: return 1;
      default:                  return 2;
    endcase
  endfunction

  function automatic bit rises(phase_t p);
    return p == PH_RED_UP || p == PH_BLUE_UP || p == PH_GREEN_UP;
  endfunction

  function automatic void reset_fade_model();
    pwm_cnt     = '0;
    drive       = '0;
    lvl[0]      = '0;
    lvl[1]      = '0;
    lvl[2]      = '0;
    fade_ph     = PH_RED_UP;
    step_dly    = '0;
    step_period = STEP_TICKS_RST;
  endfunction

  // Move one level a step, skipping phases that are already at their limit
  function automatic void advance_fade();
    phase_t p;
    bit     found;
    int     ch;
    p = (fade_ph > PH_BLUE_DN) ? PH_RED_UP : fade_ph;
    found = 1'b0;
    for (int n = 0; n < NUM_PH; n++) begin
      if (!found) begin
        ch = channel_of(p);
        if (rises(p) ? (lvl[ch] < LEVEL_TOP) : (lvl[ch] != '0))
          found = 1'b1;
        else
          p = (p == PH_BLUE_DN) ? PH_RED_UP : phase_t'(p + 1'b1);
      end
    end
    fade_ph = p;
    if (found) begin
      ch = channel_of(p);
      lvl[ch] = rises(p) ? level_t'(lvl[ch] + 1'b1) : level_t'(lvl[ch] - 1'b1);
    end
  endfunction

  // Apply one input transfer and return the LED state it reports
  function automatic led_state_t pwm_tick(logic tick);
    logic [7:0] thr [3];
    led_state_t s;
    if (tick) begin
      for (int c = 0; c < 3; c++) thr[c] = GAMMA_BYTES[8*lvl[c] +: 8];
      if (pwm_cnt == '0) begin
        drive   = '0;
        pwm_cnt = PWM_RELOAD;
      end
      if (pwm_cnt <= thr[0]) drive[2] = 1'b1;
      if (pwm_cnt <= thr[1]) drive[1] = 1'b1;
      if (pwm_cnt <= thr[2]) drive[0] = 1'b1;
      pwm_cnt = pwm_cnt - 8'd1;
      if (step_dly == '0) begin
        advance_fade();
        step_dly = ((step_period == '0) ? 16'd1 : step_period) - 16'd1;
      end else begin
        step_dly = step_dly - 16'd1;
      end
    end
    s.red_on   = drive[2];
    s.green_on = drive[1];
    s.blue_on  = drive[0];
    s.red      = lvl[0];
    s.green    = lvl[1];
    s.blue     = lvl[2];
    s.phase    = fade_ph;
    return s;
  endfunction

  // Predict on accepted inputs and config writes, check accepted results
  always @(posedge clk) begin
    led_state_t want;
    led_state_t got;
    in_fired  <= rst_n && in_tvalid && in_tready;
    cfg_fired <= rst_n && cfg_valid && cfg_ready;
    if (!rst_n) begin
      reset_fade_model();
    end else begin
      if (cfg_valid && cfg_ready) step_period = cfg_data;
      if (in_tvalid && in_tready) led_expect_q.push_back(pwm_tick(in_tdata[0]));
      if (out_tvalid && out_tready) begin
        got.red_on   = out_tdata[0];
        got.green_on = out_tdata[1];
        got.blue_on  = out_tdata[2];
        got.red      = out_tdata[7:3];
        got.green    = out_tdata[12:8];
        got.blue     = out_tdata[17:13];
        got.phase    = out_tdata[20:18];
        results_seen++;
        if (led_expect_q.size() == 0) begin
          report("unexpected result transfer", 0, 1);
        end else begin
          want = led_expect_q.pop_front();
          if (got.red_on !== want.red_on)     report("red_drive", want.red_on, got.red_on);
          if (got.green_on !== want.green_on) report("green_drive", want.green_on, got.green_on);
          if (got.blue_on !== want.blue_on)   report("blue_drive", want.blue_on, got.blue_on);
          if (got.red !== want.red)           report("red_level", want.red, got.red);
          if (got.green !== want.green)       report("green_level", want.green, got.green);
          if (got.blue !== want.blue)         report("blue_level", want.blue, got.blue);
          if (got.phase !== want.phase)       report("fade_phase", want.phase, got.phase);
          if (out_tdata[23:21] !== 3'b000)    report("out_tdata pad", 0, out_tdata[23:21]);
        end
      end
    end
  end

  // Drive ticks and config writes from the job queue
  always @(negedge clk) begin
    logic         nv_in;
    logic         nv_cfg;
    logic [7:0]   nd_in;
    logic [15:0]  nd_cfg;
    pending_job_t job;
    nv_in  = in_tvalid;
    nv_cfg = cfg_valid;
    nd_in  = in_tdata;
    nd_cfg = cfg_data;
    if (rst_n) begin
      quiet_cycles = (led_expect_q.size() == 0) ? quiet_cycles + 1 : 0;
      if (in_tvalid && in_fired) nv_in = 1'b0;
      if (cfg_valid && cfg_fired) nv_cfg = 1'b0;
      if (!nv_in && !nv_cfg && job_q.size() > 0) begin
        job = job_q[0];
        case (job.kind)
          JOB_TICK: begin
            if (job.gapless || $urandom_range(99) >= 9) begin
              nv_in = 1'b1;
              nd_in = {7'b0, job.val[0]};
              void'(job_q.pop_front());
            end
          end
          JOB_CFG: begin
            // write only once the block has drained and settled
            if (quiet_cycles >= 3 && !in_tvalid) begin
              nv_cfg = 1'b1;
              nd_cfg = job.val;
              void'(job_q.pop_front());
            end
          end
          default: begin
            if (quiet_cycles >= 1 && !in_tvalid) void'(job_q.pop_front());
          end
        endcase
      end
    end
    in_tvalid <= nv_in;
    in_tdata  <= nd_in;
    cfg_valid <= nv_cfg;
    cfg_data  <= nd_cfg;
  end

  // Result sink: random stalls, one long hold, one stretch always ready
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_tready <= 1'b0;
      sink_hold  <= sink_hold - 1;
    end else if (!long_hold_done && results_seen >= 300) begin
      out_tready     <= 1'b0;
      sink_hold      <= 60;
      long_hold_done <= 1'b1;
    end else if (results_seen >= 700 && results_seen < 1000) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 9);
    end
  end

  function automatic void add_tick(logic tick, bit gapless);
    pending_job_t j;
    j.kind    = JOB_TICK;
    j.val     = {15'b0, tick};
    j.gapless = gapless;
    job_q.push_back(j);
  endfunction

  function automatic void add_cfg(logic [15:0] period);
    pending_job_t j;
    j.kind    = JOB_CFG;
    j.val     = period;
    j.gapless = 1'b0;
    job_q.push_back(j);
  endfunction

  function automatic void add_random_ticks(int count, int calm_from, int calm_to);
    for (int i = 0; i < count; i++)
      add_tick($urandom_range(99) < 88, i >= calm_from && i < calm_to);
  endfunction

  // Build the stimulus, run reset, wait for the drain and give the verdict
  initial begin
    pending_job_t drain;
    drain.kind    = JOB_DRAIN;
    drain.val     = '0;
    drain.gapless = 1'b0;

    // directed: one step per tick, idle reports at start, middle and between bursts
    add_cfg(16'd1);
    add_tick(1'b0, 1'b0);
    repeat (6) add_tick(1'b1, 1'b0);
    add_tick(1'b0, 1'b0);
    repeat (4) add_tick(1'b1, 1'b0);
    repeat (2) add_tick(1'b0, 1'b0);
    repeat (10) add_tick(1'b1, 1'b0);

    // random at one step per tick: full fade cycles and phase skips
    add_random_ticks(350, 0, 0);
    job_q.push_back(drain);
    add_random_ticks(350, 50, 250);

    // zero period acts as one step per tick
    add_cfg(16'd0);
    add_random_ticks(300, 0, 0);
    add_cfg(16'd3);
    add_random_ticks(400, 0, 0);
    add_cfg(16'd2);
    add_random_ticks(150, 0, 0);
    // longest period: first step then a long wait
    add_cfg(16'hFFFF);
    add_random_ticks(75, 0, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (job_q.size() != 0 || in_tvalid || cfg_valid || led_expect_q.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
